/* hw/rtl/dcdf_pkg.sv */
// ----------------------------------------------------------------------------
// dcdf_pkg
// Types and constants shared by the damage distribution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcdf_pkg;

  localparam int unsigned ProbW = 25;
  localparam int unsigned CumW  = 26;
  localparam logic [ProbW-1:0] ProbMax   = 25'h1FF_FFFF;
  localparam logic [CumW-1:0]  CumCap    = 26'd33554432;
  localparam logic [CumW-1:0]  StopLevel = 26'd16777215;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_WR_VULN  = 3'd0,
    OP_WR_MEAN  = 3'd1,
    OP_WR_INT   = 3'd2,
    OP_CLR_INT  = 3'd3,
    OP_CMP_FULL = 3'd4,
    OP_CMP_ONE  = 3'd5,
    OP_NOP6     = 3'd6,
    OP_NOP7     = 3'd7
  } op_e;

  // Configuration register indexes.
  localparam logic CFG_INT_USED = 1'b0;
  localparam logic CFG_DMG_USED = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  vuln_slot;
    logic [6:0]  intensity_bin;
    logic [5:0]  damage_bin;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [25:0] cum_prob;
    logic [5:0]  bin_number;
    logic [31:0] mean_damage;
    logic        last;
  } out_word_t;

  function automatic logic [ProbW-1:0] sat25(input logic [31:0] v);
    sat25 = (v[31:25] != 7'd0) ? ProbMax : v[ProbW-1:0];
  endfunction

  // Saturating accumulate at 2.0.
  function automatic logic [CumW-1:0] cum_add(input logic [CumW-1:0] c,
                                              input logic [ProbW:0] a);
    logic [CumW:0] s;
    s = {1'b0, c} + {1'b0, a};
    cum_add = (s > {1'b0, CumCap}) ? CumCap : s[CumW-1:0];
  endfunction

endpackage

/* hw/rtl/dcdf_ram.sv */
// ----------------------------------------------------------------------------
// dcdf_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcdf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read on one address a cycle; a write reads out the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* hw/rtl/damage_cdf_from_vulnerability.sv */
// A write or an unused operation passes S_DSTART back to S_IDLE; a clear sweeps
// the intensity vector in S_ICLR. Full compute does one vulnerability read and
// multiply-accumulate a cycle over the used intensity bins of each used damage
// bin, then emits a word, ending early at the stop level. Single-bin compute
// reads one entry per used damage bin. Output stalls hold the sequencer. After
// reset the vulnerability and intensity stores are zeroed; no word is taken.
// ----------------------------------------------------------------------------
// damage_cdf_from_vulnerability
// Cumulative damage distribution from a stored vulnerability matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module damage_cdf_from_vulnerability
  import dcdf_pkg::*;
#(
  parameter int unsigned VULN_SLOTS = 16,
  parameter int unsigned INT_BINS   = 64,
  parameter int unsigned DMG_BINS   = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned SlotW = (VULN_SLOTS > 1) ? $clog2(VULN_SLOTS) : 1;
  localparam int unsigned IbW   = (INT_BINS > 1) ? $clog2(INT_BINS) : 1;
  localparam int unsigned DbW   = (DMG_BINS > 1) ? $clog2(DMG_BINS) : 1;
  localparam int unsigned VDepth = VULN_SLOTS * INT_BINS * DMG_BINS;
  localparam int unsigned VaW   = $clog2(VDepth + 1);
  localparam int unsigned VaddrW = (VDepth > 1) ? $clog2(VDepth) : 1;
  localparam int unsigned IRamW = (INT_BINS > 1) ? $clog2(INT_BINS) : 1;
  localparam int unsigned DRamW = (DMG_BINS > 1) ? $clog2(DMG_BINS) : 1;
  localparam int unsigned IDepth = (INT_BINS > 1) ? INT_BINS : 2;
  localparam int unsigned DDepth = (DMG_BINS > 1) ? DMG_BINS : 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ICLR, S_DSTART, S_RD, S_MAC, S_MREQ, S_MRD, S_EMIT
  } state_e;

  state_e state_q;
  logic [VaW-1:0]   sweep_q;
  logic [6:0]       int_used_q;
  logic [5:0]       dmg_used_q;
  in_word_t         item_q;
  logic [7:0]       ni_q;
  logic [6:0]       nd_q;
  logic [6:0]       d_q;
  logic [8:0]       i_q;
  logic             pend_q;
  logic [CumW-1:0]  cum_q;
  logic             colok_q;
  logic             out_valid_q;
  out_word_t        out_q;

  // Memory ports.
  logic             v_we, i_we, m_we;
  logic [VaddrW-1:0] v_addr;
  logic [IRamW-1:0] i_addr;
  logic [DRamW-1:0] m_addr;
  logic [ProbW-1:0] v_wdata, v_rdata, i_wdata, i_rdata;
  logic [31:0]      m_rdata;

  dcdf_ram #(.Width(ProbW), .Depth(VDepth)) u_vuln (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(v_wdata), .rdata_o(v_rdata));
  dcdf_ram #(.Width(ProbW), .Depth(IDepth)) u_int (
    .clk_i, .we_i(i_we), .addr_i(i_addr), .wdata_i(i_wdata), .rdata_o(i_rdata));
  dcdf_ram #(.Width(32), .Depth(DDepth)) u_mean (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(item_q.value),
    .rdata_o(m_rdata));

  // Address checks on the held word.
  logic slot_ok, ib_ok, db_ok;
  logic [SlotW-1:0] slot0;
  logic [IbW-1:0]   ib0;
  logic [DbW-1:0]   db0;
  assign slot_ok = 32'(item_q.vuln_slot) < VULN_SLOTS;
  assign ib_ok   = item_q.intensity_bin >= 7'd1 && 32'(item_q.intensity_bin) <= INT_BINS;
  assign db_ok   = item_q.damage_bin >= 6'd1 && 32'(item_q.damage_bin) <= DMG_BINS;
  assign slot0   = SlotW'(item_q.vuln_slot);
  assign ib0     = IbW'(item_q.intensity_bin - 7'd1);
  assign db0     = DbW'(item_q.damage_bin - 6'd1);

  function automatic logic [VaddrW-1:0] vidx(input logic [SlotW-1:0] s,
                                             input logic [IbW-1:0] i,
                                             input logic [DbW-1:0] d);
    logic [31:0] a;
    a = (32'(s) * DMG_BINS + 32'(d)) * INT_BINS + 32'(i);
    vidx = VaddrW'(a);
  endfunction

  logic [DbW-1:0] dcur;
  logic [IbW-1:0] icur;
  assign dcur = DbW'(d_q);
  assign icur = IbW'(i_q);

  // Memory control.
  always_comb begin
    v_we = 1'b0; i_we = 1'b0; m_we = 1'b0;
    v_wdata = sat25(item_q.value);
    i_wdata = sat25(item_q.value);
    v_addr = vidx(slot0, icur, dcur);
    i_addr = IRamW'(icur);
    m_addr = DRamW'(dcur);
    unique case (state_q)
      S_CLEAR: begin
        // The intensity vector is cleared alongside the vulnerability store.
        v_we = 1'b1; v_wdata = '0; v_addr = VaddrW'(sweep_q);
        i_we = 1'b1; i_wdata = '0; i_addr = IRamW'(sweep_q);
      end
      S_ICLR: begin
        i_we = 1'b1; i_wdata = '0; i_addr = IRamW'(sweep_q);
      end
      S_DSTART: begin
        unique case (op_e'(item_q.op))
          OP_WR_VULN: begin
            v_we = slot_ok && ib_ok && db_ok;
            v_addr = vidx(slot0, ib0, db0);
          end
          OP_WR_MEAN: begin
            m_we = db_ok; m_addr = DRamW'(db0);
          end
          OP_WR_INT: begin
            i_we = ib_ok; i_addr = IRamW'(ib0);
          end
          default: ;
        endcase
      end
      S_RD: begin
        if (op_e'(item_q.op) == OP_CMP_ONE) begin
          v_addr = vidx(slot0, ib0, dcur);
        end
      end
      default: ;
    endcase
  end

  // The truncated product of two saturated probabilities needs one bit more.
  logic [2*ProbW-1:0] prod;
  logic [ProbW:0]     prod_sh;
  assign prod    = v_rdata * i_rdata;
  assign prod_sh = prod[2*ProbW-1:24];

  // A result word is loaded when the output register is free or draining.
  logic emit_go;
  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer: one vulnerability read and accumulate a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sweep_q <= '0;
      int_used_q <= 7'd64;
      dmg_used_q <= 6'd32;
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
      d_q <= '0; i_q <= '0; cum_q <= '0; ni_q <= '0; nd_q <= '0;
      colok_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_INT_USED) int_used_q <= cfg_data_i[6:0];
        else dmg_used_q <= cfg_data_i[5:0];
      end
      if (emit_go) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          sweep_q <= sweep_q + 1'b1;
          if (32'(sweep_q) == VDepth - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            ni_q <= (int_used_q == 7'd0) ? 8'd1 :
                    (32'(int_used_q) > INT_BINS) ? 8'(INT_BINS) : {1'b0, int_used_q};
            nd_q <= (dmg_used_q == 6'd0) ? 7'd1 :
                    (32'(dmg_used_q) > DMG_BINS) ? 7'(DMG_BINS) : {1'b0, dmg_used_q};
            sweep_q <= '0;
            d_q <= '0; i_q <= '0; cum_q <= '0; pend_q <= 1'b0;
            state_q <= (op_e'(in_data_i.op) == OP_CLR_INT) ? S_ICLR : S_DSTART;
          end
        end
        S_ICLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (32'(sweep_q) == INT_BINS - 1) state_q <= S_IDLE;
        end
        S_DSTART: begin
          colok_q <= slot_ok && ib_ok && ({1'b0, item_q.intensity_bin} <= ni_q);
          if (op_e'(item_q.op) == OP_CMP_FULL || op_e'(item_q.op) == OP_CMP_ONE)
            state_q <= S_RD;
          else state_q <= S_IDLE;
        end
        S_RD: begin
          // One read issued per cycle; the previous read's data accumulates.
          if (pend_q) begin
            if (op_e'(item_q.op) == OP_CMP_FULL) begin
              if (slot_ok) cum_q <= cum_add(cum_q, prod_sh);
            end
          end
          if (op_e'(item_q.op) == OP_CMP_FULL && {1'b0, i_q[7:0]} < {1'b0, ni_q}) begin
            pend_q <= 1'b1;
            i_q <= i_q + 1'b1;
          end else if (op_e'(item_q.op) == OP_CMP_ONE) begin
            state_q <= S_MAC;
          end else begin
            pend_q <= 1'b0;
            state_q <= S_MREQ;
          end
        end
        S_MAC: begin
          if (colok_q) cum_q <= cum_add(cum_q, {1'b0, v_rdata});
          state_q <= S_MREQ;
        end
        S_MREQ: state_q <= S_MRD;
        S_MRD: state_q <= S_EMIT;
        S_EMIT: begin
          if (emit_go) begin
            out_q.cum_prob <= cum_q;
            out_q.bin_number <= 6'(d_q + 7'd1);
            out_q.mean_damage <= m_rdata;
            if ((d_q + 7'd1 >= nd_q) ||
                (op_e'(item_q.op) == OP_CMP_FULL && cum_q >= StopLevel)) begin
              out_q.last <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              out_q.last <= 1'b0;
              d_q <= d_q + 7'd1;
              i_q <= '0;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the damage distribution block. A directed table
// covers field extremes, every operation and the corner cases; random
// traffic follows, mostly well-formed write/compute sequences. Each result
// word is checked against a predictor that keeps its own copy of the tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import dcdf_pkg::*;

  localparam int NSlots = 16;
  localparam int NInt   = 64;
  localparam int NDmg   = 32;
  localparam longint CycleLimit = 64'd3_000_000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  damage_cdf_from_vulnerability uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [24:0] vuln_mem [NSlots*NInt*NDmg];
  logic [31:0] mean_mem [NDmg];
  logic [24:0] int_vec [NInt];
  logic [6:0]  int_used_reg;
  logic [5:0]  dmg_used_reg;

  out_word_t cdf_expected [$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  longint cycles = 0;

  function automatic int eff(input int r, input int lim);
    if (r == 0) return 1;
    return (r > lim) ? lim : r;
  endfunction

  function automatic logic [24:0] clip25(input logic [31:0] v);
    return (v > 32'h1FF_FFFF) ? 25'h1FF_FFFF : v[24:0];
  endfunction

  function automatic logic [25:0] sum_cap(input logic [25:0] c, input longint a);
    longint s;
    s = longint'(c) + a;
    return (s > 64'd33554432) ? 26'd33554432 : s[25:0];
  endfunction

  function automatic int vidx(input int s, input int ib0, input int db0);
    return (s * NDmg + db0) * NInt + ib0;
  endfunction

  // Update the tables and queue the words that one item produces.
  task automatic predict_cdf(input in_word_t w);
    int ni, nd, s, ib, db;
    logic [25:0] cum;
    longint p;
    out_word_t r;
    ni = eff(int_used_reg, NInt);
    nd = eff(dmg_used_reg, NDmg);
    s = w.vuln_slot; ib = w.intensity_bin; db = w.damage_bin;
    cum = '0;
    case (op_e'(w.op))
      OP_WR_VULN: if (ib >= 1 && ib <= NInt && db >= 1 && db <= NDmg)
        vuln_mem[vidx(s, ib-1, db-1)] = clip25(w.value);
      OP_WR_MEAN: if (db >= 1 && db <= NDmg) mean_mem[db-1] = w.value;
      OP_WR_INT: if (ib >= 1 && ib <= NInt) int_vec[ib-1] = clip25(w.value);
      OP_CLR_INT: foreach (int_vec[i]) int_vec[i] = '0;
      OP_CMP_FULL, OP_CMP_ONE: begin
        for (int d = 0; d < nd; d++) begin
          if (w.op == OP_CMP_FULL) begin
            for (int i = 0; i < ni; i++) begin
              p = (longint'(vuln_mem[vidx(s, i, d)]) * longint'(int_vec[i])) >> 24;
              cum = sum_cap(cum, p);
            end
          end else if (ib >= 1 && ib <= ni) begin
            cum = sum_cap(cum, vuln_mem[vidx(s, ib-1, d)]);
          end
          r.cum_prob = cum;
          r.bin_number = 6'(d + 1);
          r.mean_damage = mean_mem[d];
          r.last = 1'b0;
          cdf_expected.push_back(r);
          if (w.op == OP_CMP_FULL && cum >= StopLevel) break;
        end
        cdf_expected[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Drive one word and wait for its acceptance; valid is then dropped.
  task automatic send_word(input in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_cdf(w);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_quiet();
    while (cdf_expected.size() != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_INT_USED) int_used_reg = v[6:0];
    else dmg_used_reg = v[5:0];
    @(posedge clk_i);
  endtask

  // Fill every mean-damage word so no compute reads an unwritten entry.
  task automatic fill_means();
    in_word_t w;
    for (int d = 1; d <= NDmg; d++) begin
      w = '{op: OP_WR_MEAN, vuln_slot: '0, intensity_bin: 7'd1,
            damage_bin: 6'(d), value: $urandom()};
      if (d == 1) w.value = 32'hFFFF_FFFF;
      if (d == 2) w.value = 32'h0;
      send_word(w);
    end
  endtask

  function automatic in_word_t rand_word(input int small_slots);
    in_word_t w;
    int k;
    w.value = $urandom();
    w.vuln_slot = 4'($urandom_range(small_slots - 1));
    w.intensity_bin = 7'($urandom_range(1, 8));
    w.damage_bin = 6'($urandom_range(1, NDmg));
    k = $urandom_range(99);
    if (k < 40) begin
      w.op = OP_WR_VULN;
      w.value = (k < 4) ? $urandom() : 32'($urandom_range(0, 32'h0FF_FFFF) >> $urandom_range(4));
    end else if (k < 55) begin
      w.op = OP_WR_INT;
      w.value = (k < 42) ? $urandom() : 32'($urandom_range(0, 32'h100_0000));
    end else if (k < 58) w.op = OP_WR_MEAN;
    else if (k < 60) w.op = OP_CLR_INT;
    else if (k < 78) w.op = OP_CMP_FULL;
    else if (k < 94) w.op = OP_CMP_ONE;
    else w.op = (k < 97) ? OP_NOP6 : OP_NOP7;
    if ($urandom_range(19) == 0) begin
      // Occasional out-of-range addressing and the full slot range.
      w.intensity_bin = 7'($urandom_range(127));
      w.damage_bin = 6'($urandom_range(63));
      w.vuln_slot = 4'($urandom_range(15));
    end
    return w;
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    out_ready_i <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cdf_expected.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_data_o);
        errors++;
      end else begin
        if (out_data_o.cum_prob !== cdf_expected[0].cum_prob) begin
          $display("%0t: cum_prob expected %0d actual %0d", $time,
                   cdf_expected[0].cum_prob, out_data_o.cum_prob);
          errors++;
        end
        if (out_data_o.bin_number !== cdf_expected[0].bin_number) begin
          $display("%0t: bin_number expected %0d actual %0d", $time,
                   cdf_expected[0].bin_number, out_data_o.bin_number);
          errors++;
        end
        if (out_data_o.mean_damage !== cdf_expected[0].mean_damage) begin
          $display("%0t: mean_damage expected %h actual %h", $time,
                   cdf_expected[0].mean_damage, out_data_o.mean_damage);
          errors++;
        end
        if (out_data_o.last !== cdf_expected[0].last) begin
          $display("%0t: last expected %b actual %b", $time,
                   cdf_expected[0].last, out_data_o.last);
          errors++;
        end
        void'(cdf_expected.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    in_word_t    w;
    bit          has_check;
    logic [25:0] first_cum;
  } dir_row_t;

  dir_row_t dir_rows [$];
  in_word_t wv;

  initial begin
    foreach (vuln_mem[i]) vuln_mem[i] = '0;
    foreach (mean_mem[i]) mean_mem[i] = '0;
    foreach (int_vec[i]) int_vec[i] = '0;
    int_used_reg = 7'd64;
    dmg_used_reg = 6'd32;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_means();

    // Directed table; a checked row gives the cumulative value of the first word.
    dir_rows = '{
      '{'{OP_CMP_FULL, 4'd0, 7'd1, 6'd1, 32'd0}, 1, 26'd0},
      '{'{OP_CMP_ONE, 4'd15, 7'd64, 6'd1, 32'd0}, 1, 26'd0},
      '{'{OP_WR_VULN, 4'd15, 7'd64, 6'd32, 32'hFFFF_FFFF}, 0, 26'd0},
      '{'{OP_WR_VULN, 4'd0, 7'd1, 6'd1, 32'h0100_0000}, 0, 26'd0},
      '{'{OP_WR_VULN, 4'd0, 7'd1, 6'd2, 32'h0080_0000}, 0, 26'd0},
      '{'{OP_WR_VULN, 4'd0, 7'd0, 6'd1, 32'h0155_5555}, 0, 26'd0},
      '{'{OP_WR_VULN, 4'd0, 7'd65, 6'd33, 32'h0155_5555}, 0, 26'd0},
      '{'{OP_WR_VULN, 4'd0, 7'd127, 6'd63, 32'h0155_5555}, 0, 26'd0},
      '{'{OP_CMP_ONE, 4'd0, 7'd1, 6'd0, 32'd0}, 1, 26'h100_0000},
      '{'{OP_CMP_ONE, 4'd0, 7'd0, 6'd0, 32'd0}, 1, 26'd0},
      '{'{OP_CMP_ONE, 4'd0, 7'd127, 6'd0, 32'd0}, 1, 26'd0},
      '{'{OP_WR_INT, 4'd0, 7'd1, 6'd1, 32'h0100_0000}, 0, 26'd0},
      '{'{OP_WR_INT, 4'd0, 7'd0, 6'd1, 32'hFFFF_FFFF}, 0, 26'd0},
      '{'{OP_CMP_FULL, 4'd0, 7'd1, 6'd1, 32'd0}, 1, 26'h100_0000},
      '{'{OP_WR_INT, 4'd0, 7'd64, 6'd1, 32'hFFFF_FFFF}, 0, 26'd0},
      '{'{OP_CMP_FULL, 4'd15, 7'd1, 6'd1, 32'd0}, 0, 26'd0},
      '{'{OP_CMP_ONE, 4'd15, 7'd64, 6'd1, 32'd0}, 0, 26'd0},
      '{'{OP_NOP6, 4'd15, 7'd127, 6'd63, 32'hFFFF_FFFF}, 0, 26'd0},
      '{'{OP_NOP7, 4'd0, 7'd0, 6'd0, 32'd0}, 0, 26'd0},
      '{'{OP_CLR_INT, 4'd0, 7'd0, 6'd0, 32'd0}, 0, 26'd0},
      '{'{OP_CMP_FULL, 4'd15, 7'd1, 6'd1, 32'd0}, 1, 26'd0},
      '{'{OP_WR_MEAN, 4'd0, 7'd0, 6'd0, 32'h1234_5678}, 0, 26'd0},
      '{'{OP_WR_MEAN, 4'd0, 7'd0, 6'd63, 32'h1234_5678}, 0, 26'd0}
    };
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w);
      // Typed-in first-word value must agree with the predictor as well.
      if (dir_rows[i].has_check) begin
        int n;
        n = eff(dmg_used_reg, NDmg);
        if (dir_rows[i].w.op == OP_CMP_FULL && dir_rows[i].first_cum >= StopLevel) n = 1;
        if (cdf_expected.size() < n ||
            cdf_expected[cdf_expected.size()-n].cum_prob !== dir_rows[i].first_cum) begin
          $display("%0t: directed row %0d expected %0d actual %0d", $time, i,
                   dir_rows[i].first_cum, cdf_expected[cdf_expected.size()-n].cum_prob);
          errors++;
        end
      end
    end
    drain_quiet();

    // Register extremes, including zero and out-of-range values.
    write_reg(CFG_INT_USED, 32'd0);
    write_reg(CFG_DMG_USED, 32'd0);
    send_word('{OP_CMP_FULL, 4'd0, 7'd1, 6'd1, 32'd0});
    send_word('{OP_CMP_ONE, 4'd0, 7'd1, 6'd1, 32'd0});
    drain_quiet();
    write_reg(CFG_INT_USED, 32'hFFFF_FFFF);
    write_reg(CFG_DMG_USED, 32'hFFFF_FFFF);
    send_word('{OP_CMP_ONE, 4'd0, 7'd1, 6'd1, 32'd0});
    drain_quiet();

    // Random phases: small dimensions in the first three keep compute words short; the last uses the full sizes.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_INT_USED, (ph == 3) ? 32'd64 : 32'($urandom_range(1, 8)));
      write_reg(CFG_DMG_USED, (ph == 3) ? 32'd32 : 32'($urandom_range(1, 12)));
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 19 : 0;
      for (int n = 0; n < ((ph == 3) ? 20 : 70); n++) begin
        wv = rand_word(ph == 3 ? 2 : 3);
        if (ph == 2 && n == 20) begin
          // Long receiver hold-off while words keep coming.
          fork
            begin
              recv_hold = 1'b1;
              repeat (600) @(posedge clk_i);
              recv_hold = 1'b0;
            end
          join_none
        end
        send_word(wv);
      end
      drain_quiet();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
